@@ rtl/sjfq_pkg.sv @@
// Shared types and constants for the shortest-job-first queue.
`default_nettype none

package sjfq_pkg;

    // Default number of queue slots
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int JOB_W    = 4;
    localparam int DUR_W    = 16;
    localparam int STATUS_W = 2;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } sjfq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic ins;        // sorted insert of the captured job
        logic rem;        // pop the head
        logic rep_full;   // report dropped insert
        logic rep_empty;  // report empty remove
    } sjfq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_rem;     // captured beat is a remove
        logic full;
        logic empty;
    } sjfq_sts_t;

endpackage

`default_nettype wire

@@ rtl/sjfq_ctrl.sv @@
// Controller state machine for the shortest-job-first queue.
`default_nettype none

module sjfq_ctrl
    import sjfq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire sjfq_sts_t sts,
    output sjfq_cmd_t      cmd
);

    sjfq_state_t state_reg;
    sjfq_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                if (sts.op_rem) begin
                    cmd.rem       = !sts.empty;
                    cmd.rep_empty = sts.empty;
                end else begin
                    cmd.ins      = !sts.full;
                    cmd.rep_full = sts.full;
                end
            end
            S_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sjfq_dpath.sv @@
// Datapath: sorted row of job slots, fill count and result register.
`default_nettype none

module sjfq_dpath
    import sjfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_opcode,
    input  wire logic [JOB_W-1:0] in_job_id,
    input  wire logic [DUR_W-1:0] in_duration,
    input  wire sjfq_cmd_t        cmd,
    output sjfq_sts_t             sts,
    output logic [JOB_W-1:0]      res_job,
    output logic [STATUS_W-1:0]   res_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Captured input beat
    logic             op_reg;
    logic [JOB_W-1:0] job_reg;
    logic [DUR_W-1:0] dur_reg;

    // Slot row, head at index 0
    logic [JOB_W-1:0] entry_job_reg [DEPTH];
    logic [DUR_W-1:0] entry_dur_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;

    // Result
    logic [JOB_W-1:0]    res_job_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // Per-slot compare: live slot longer than the new job moves down
    logic [DEPTH-1:0] gt_vec;
    logic [DEPTH:0]   gt_prev;   // gt_prev[i] is gt_vec[i-1]

    // Neighbor views of the row
    logic [JOB_W-1:0] prev_job [DEPTH];
    logic [DUR_W-1:0] prev_dur [DEPTH];
    logic [JOB_W-1:0] succ_job [DEPTH];
    logic [DUR_W-1:0] succ_dur [DEPTH];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt_vec[i] = (CNT_W'(i) < count_reg) && (entry_dur_reg[i] > dur_reg);
        end
        gt_prev = {gt_vec, 1'b0};
    end

    always_comb begin
        prev_job[0] = job_reg;
        prev_dur[0] = dur_reg;
        for (int i = 1; i < DEPTH; i++) begin
            prev_job[i] = entry_job_reg[i-1];
            prev_dur[i] = entry_dur_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            succ_job[i] = entry_job_reg[i+1];
            succ_dur[i] = entry_dur_reg[i+1];
        end
        succ_job[DEPTH-1] = entry_job_reg[DEPTH-1];
        succ_dur[DEPTH-1] = entry_dur_reg[DEPTH-1];
    end

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_opcode;
            job_reg <= in_job_id;
            dur_reg <= in_duration;
        end
    end

    // Slot row: shift down behind the insert point, or shift up on pop
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (cmd.ins) begin
                if (gt_prev[i]) begin
                    entry_job_reg[i] <= prev_job[i];
                    entry_dur_reg[i] <= prev_dur[i];
                end else if (gt_vec[i] || (count_reg == CNT_W'(i))) begin
                    entry_job_reg[i] <= job_reg;
                    entry_dur_reg[i] <= dur_reg;
                end
            end else if (cmd.rem) begin
                entry_job_reg[i] <= succ_job[i];
                entry_dur_reg[i] <= succ_dur[i];
            end
        end
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.ins) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (cmd.rem) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.rem) begin
            res_job_reg    <= entry_job_reg[0];
            res_status_reg <= STS_DONE;
        end else if (cmd.ins) begin
            res_job_reg    <= '0;
            res_status_reg <= STS_DONE;
        end else if (cmd.rep_full) begin
            res_job_reg    <= '0;
            res_status_reg <= STS_FULL;
        end else if (cmd.rep_empty) begin
            res_job_reg    <= '0;
            res_status_reg <= STS_EMPTY;
        end
    end

    assign sts.op_rem = (op_reg == OP_REMOVE);
    assign sts.full   = (count_reg == CNT_W'(DEPTH));
    assign sts.empty  = (count_reg == '0);
    assign res_job    = res_job_reg;
    assign res_status = res_status_reg;

endmodule

`default_nettype wire

@@ rtl/shortest_job_first_queue_top.sv @@
// Top level of the shortest-job-first queue: controller, datapath and checks.
`default_nettype none

// Bounded queue of up to DEPTH jobs kept sorted by duration, shortest at the
// head; equal durations keep arrival order. Each input beat is an insert
// (opcode 0) or a remove (opcode 1) and yields exactly one result beat. An
// insert into a full queue is dropped with status 1; a remove from an empty
// queue returns job 0 with status 2. One beat is handled at a time, in order:
// capture, one update of the slot row, result presented. The result becomes
// valid once the controller has passed from S_IDLE through S_EXEC into S_RESP
// and stays until m_ready takes it; s_ready returns the cycle after the result
// is taken. The slot row updates at once because every slot compares its own
// duration with the new one in parallel.

module shortest_job_first_queue_top
    import sjfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_opcode,
    input  wire logic [JOB_W-1:0]    s_job_id,
    input  wire logic [DUR_W-1:0]    s_duration,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [JOB_W-1:0]         m_removed_job,
    output logic [STATUS_W-1:0]      m_status
);

    sjfq_cmd_t cmd;
    sjfq_sts_t sts;

    sjfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sjfq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_opcode   (s_opcode),
        .in_job_id   (s_job_id),
        .in_duration (s_duration),
        .cmd         (cmd),
        .sts         (sts),
        .res_job     (m_removed_job),
        .res_status  (m_status)
    );

    // Never take a new beat while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    // An accepted beat closes the input side until its result goes out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("input side not closed after accept");

    // Result status is one of the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STS_DONE || m_status == STS_FULL ||
                     m_status == STS_EMPTY))
        else $error("undefined result status");

    // A dropped insert or an empty remove returns job 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STS_DONE) |-> (m_removed_job == '0))
        else $error("nonzero job on failed request");

endmodule

`default_nettype wire

@@ dv/sjfq_checker.sv @@
// Checker for the shortest-job-first queue: predicts each result beat and compares it.
`timescale 1ns / 1ps

module sjfq_checker
    import sjfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_opcode,
    input  wire logic [JOB_W-1:0]    s_job_id,
    input  wire logic [DUR_W-1:0]    s_duration,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [JOB_W-1:0]    m_removed_job,
    input  wire logic [STATUS_W-1:0] m_status,
    output int                       fail_count,
    output int                       pending,
    output int                       beats_checked,
    output int                       full_drops,
    output int                       empty_pops,
    output int                       peak_fill
);

    typedef struct packed {
        logic [JOB_W-1:0] job;
        logic [DUR_W-1:0] dur;
    } job_slot_t;

    typedef struct packed {
        logic [JOB_W-1:0]    removed_job;
        logic [STATUS_W-1:0] status;
    } dispatch_t;

    // Shadow copy of the sorted job row
    job_slot_t sorted_jobs [DEPTH];
    int        live_jobs = 0;
    dispatch_t dispatch_q [$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        beats_checked = 0;
        full_drops    = 0;
        empty_pops    = 0;
        peak_fill     = 0;
    end

    // Apply one request to the shadow queue and return the dispatch it yields
    function automatic dispatch_t schedule_job(logic op, logic [JOB_W-1:0] new_job,
                                               logic [DUR_W-1:0] new_dur);
        dispatch_t res;
        int        pos;
        res.removed_job = '0;
        res.status      = STS_DONE;
        if (op == OP_INSERT) begin
            if (live_jobs >= DEPTH) begin
                res.status = STS_FULL;
            end else begin
                // walk back past every longer job; ties stay ahead of the new one
                pos = live_jobs;
                while (pos > 0 && sorted_jobs[pos-1].dur > new_dur) begin
                    sorted_jobs[pos] = sorted_jobs[pos-1];
                    pos--;
                end
                sorted_jobs[pos].job = new_job;
                sorted_jobs[pos].dur = new_dur;
                live_jobs++;
            end
        end else if (live_jobs == 0) begin
            res.status = STS_EMPTY;
        end else begin
            res.removed_job = sorted_jobs[0].job;
            for (pos = 1; pos < live_jobs; pos++)
                sorted_jobs[pos-1] = sorted_jobs[pos];
            live_jobs--;
        end
        return res;
    endfunction

    // Compare result beats first (they belong to older requests), then predict
    always @(posedge aclk) begin : watch
        dispatch_t want;
        if (!aresetn) begin
            live_jobs = 0;
            dispatch_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (dispatch_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: expected none, actual job %0d status %0d",
                             $time, m_removed_job, m_status);
                end else begin
                    want = dispatch_q.pop_front();
                    beats_checked++;
                    if (m_removed_job !== want.removed_job) begin
                        fail_count++;
                        $display("%0t: removed_job mismatch: expected %0d, actual %0d",
                                 $time, want.removed_job, m_removed_job);
                    end
                    if (m_status !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = schedule_job(s_opcode, s_job_id, s_duration);
                dispatch_q.push_back(want);
                if (want.status == STS_FULL)
                    full_drops++;
                if (want.status == STS_EMPTY)
                    empty_pops++;
                if (live_jobs > peak_fill)
                    peak_fill = live_jobs;
            end
        end
        pending = dispatch_q.size();
    end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the shortest-job-first queue: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module testbench;
    import sjfq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RANDOM_REQS = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    // Receiver stall modes
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_MOSTLY = 1;
    localparam int RDY_RARELY = 2;
    localparam int RDY_HELD   = 3;

    logic                aclk;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic                s_opcode   = OP_INSERT;
    logic [JOB_W-1:0]    s_job_id   = '0;
    logic [DUR_W-1:0]    s_duration = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [JOB_W-1:0]    m_removed_job;
    logic [STATUS_W-1:0] m_status;

    int fail_count, pending, beats_checked, full_drops, empty_pops, peak_fill;
    int quiet_cycles = 0;
    int ready_mode   = RDY_ALWAYS;
    int ready_run    = 0;

    shortest_job_first_queue_top #(.DEPTH(DEPTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_job_id      (s_job_id),
        .s_duration    (s_duration),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_removed_job (m_removed_job),
        .m_status      (m_status)
    );

    sjfq_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_job_id      (s_job_id),
        .s_duration    (s_duration),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_removed_job (m_removed_job),
        .m_status      (m_status),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .full_drops    (full_drops),
        .empty_pops    (empty_pops),
        .peak_fill     (peak_fill)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: switches between stall patterns after runs of random length
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            ready_mode <= $urandom_range(RDY_ALWAYS, RDY_HELD);
            ready_run  <= $urandom_range(8, 60);
        end else begin
            ready_run <= ready_run - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
            default:    m_ready <= 1'b0;
        endcase
    end

    // Watchdog: ends the run when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("shortest_job_first_queue_top regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until it is taken
    task automatic send_req(logic op, logic [JOB_W-1:0] job, logic [DUR_W-1:0] dur);
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_job_id   <= job;
        s_duration <= dur;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stop sending until every outstanding result beat has been taken
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int               sent;
        int               burst;
        int               gap;
        int               insert_pct;
        int               phase_left;
        logic             op;
        logic [JOB_W-1:0] job;
        logic [DUR_W-1:0] dur;

        sent       = 0;
        insert_pct = 50;
        phase_left = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty remove, field extremes, equal durations, last entry out
        send_req(OP_REMOVE, 4'hF, 16'hFFFF);
        send_req(OP_INSERT, 4'hF, 16'hFFFF);
        send_req(OP_INSERT, 4'h0, 16'h0000);
        send_req(OP_INSERT, 4'h7, 16'h0000);
        send_req(OP_INSERT, 4'h3, 16'hFFFF);
        send_req(OP_INSERT, 4'h9, 16'h8000);
        send_req(OP_INSERT, 4'hA, 16'h0001);
        repeat (6)
            send_req(OP_REMOVE, 4'($urandom), 16'($urandom));
        send_req(OP_REMOVE, 4'h0, 16'h0000);
        send_req(OP_INSERT, 4'h5, 16'h1234);
        send_req(OP_REMOVE, 4'hA, 16'h5555);
        wait_for_results();

        // Random: phases lean toward filling or draining so both limits get hit
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++) begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       insert_pct = 15;
                        1:       insert_pct = 50;
                        2:       insert_pct = 85;
                        default: insert_pct = 97;
                    endcase
                    phase_left = $urandom_range(20, 60);
                end
                phase_left--;
                op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                job = 4'($urandom);
                // small keys give frequent ties; the rest spread over the range, hit the extremes or cluster at the top
                case ($urandom_range(0, 3))
                    0:       dur = 16'($urandom_range(0, 7));
                    1:       dur = 16'($urandom);
                    2:       dur = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: dur = 16'hFFF8 + 16'($urandom_range(0, 7));
                endcase
                send_req(op, job, dur);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Checked %0d result beats: %0d dropped inserts on a full queue,",
                 beats_checked, full_drops);
        $display("%0d removes on an empty one, peak occupancy %0d of %0d slots.",
                 empty_pops, peak_fill, DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("shortest_job_first_queue_top regression: pass");
        end else begin
            $display("shortest_job_first_queue_top regression: fail");
        end
        $finish;
    end

endmodule
